// ===== design/mtef_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event filter package
// Shared types, constants and helper functions for the track event filter.
// ----------------------------------------------------------------------------
package mtef_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned TAIL_MAX    = 3;

    localparam logic [27:0] DELTA_MAX   = 28'hFFFFFFF;
    localparam logic [7:0]  ST_SYSEX    = 8'hF0;
    localparam logic [7:0]  ST_SYSEX_CT = 8'hF7;
    localparam logic [7:0]  ST_META     = 8'hFF;
    localparam logic [7:0]  META_EOT    = 8'h2F;
    localparam logic [7:0]  META_TEMPO  = 8'h51;
    localparam logic [7:0]  ST_RESET    = 8'h80;
    localparam logic [3:0]  HI_PROG     = 4'hC;
    localparam logic [3:0]  HI_PRESS    = 4'hD;
    localparam logic [3:0]  HI_SYSTEM   = 4'hF;
    localparam logic [7:0]  TEMPO_MIN_LEN = 8'd3;

    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA   = 4'd2,
        PH_SYSLEN = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_SKIP   = 4'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last_of_run;
    } t_out_item;

    // One burst of output bytes: optional delta quantity, then 1..3 tail bytes.
    // The first tail byte sits at the highest used index.
    typedef struct packed {
        logic                          has_delta;
        logic [27:0]                   delta;
        logic [1:0]                    n_tail;
        logic [TAIL_MAX-1:0][7:0]      tail;
    } t_job;

    typedef struct packed {
        t_phase phase;
        logic   carried_zero;
    } t_front_stat;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    function automatic logic [1:0] data_len(input logic [7:0] st);
        logic [3:0] hi;
        hi = st[7:4];
        if (hi == HI_PROG || hi == HI_PRESS || hi == HI_SYSTEM) begin
            return 2'd1;
        end
        return 2'd2;
    endfunction

    function automatic logic status_kept(input logic [7:0] st);
        return (st[7:4] != HI_PRESS) && (st[7:4] != HI_SYSTEM);
    endfunction

    function automatic logic [27:0] sat_add(input logic [27:0] a, input logic [27:0] b);
        logic [28:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[28] ? DELTA_MAX : s[27:0];
    endfunction

endpackage

// ===== design/midi_track_event_filter_unit.sv =====
// ----------------------------------------------------------------------------
// MIDI track event filter
// Filters a standard MIDI file track body down to channel voice messages except
// channel pressure, tempo and end-of-track meta events, folding dropped deltas forward.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake                      | Payload
//  in      | input     | i_in_valid / o_in_ready        | i_in_data  (byte, last)
//  out     | output    | o_out_valid / i_out_ready      | o_out_data (byte, last of run)
//
//  The parser takes one track byte per cycle while the job queue has room.
//  The emitter sends one output byte per cycle while i_out_ready is high; an input
//  byte that produces n output bytes (up to seven) occupies the emitter until its
//  last byte is sent. Output stalls fill the queue and then hold o_in_ready low.
//  Reset is synchronous, active low, and leaves the parser expecting a delta.
// ----------------------------------------------------------------------------
module midi_track_event_filter_unit #(
    parameter int unsigned QUEUE_DEPTH = mtef_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mtef_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mtef_pkg::t_out_item o_out_data
);

    logic                  q_in_ready;
    logic                  fe_job_valid;
    mtef_pkg::t_job        fe_job;
    mtef_pkg::t_front_stat fe_stat;
    logic                  q_out_valid;
    mtef_pkg::t_job        q_job;
    logic                  be_job_ready;
    mtef_pkg::t_back_stat  be_stat;

    assign o_in_ready = q_in_ready;

    mtef_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_data      (i_in_data),
        .i_q_ready   (q_in_ready),
        .o_job_valid (fe_job_valid),
        .o_job       (fe_job),
        .o_stat      (fe_stat)
    );

    mtef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_job_valid),
        .i_job   (fe_job),
        .o_ready (q_in_ready),
        .o_valid (q_out_valid),
        .o_job   (q_job),
        .i_ready (be_job_ready)
    );

    mtef_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_out_valid),
        .i_job       (q_job),
        .o_job_ready (be_job_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out_data),
        .i_ready     (i_out_ready),
        .o_stat      (be_stat)
    );

    // track end returns the parser to its idle phase with no carried delta
    a_track_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.in_last
        |=> fe_stat.phase == mtef_pkg::PH_DELTA && fe_stat.carried_zero)
        else $error("parser not reset after track end");

    // a byte that is not the end of its run means the emitter still holds the job
    a_run_in_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.out_last_of_run |-> be_stat.busy)
        else $error("emitter idle in the middle of a run");

    // a job only comes from an accepted input byte
    a_job_from_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fe_job_valid |-> i_in_valid && o_in_ready)
        else $error("job produced without an input transfer");

endmodule

// ===== design/mtef_front.sv =====
// ----------------------------------------------------------------------------
// MIDI track event filter - parser front end
// Parses the track byte stream, tracks delta and running status, and hands
// each burst of output bytes to the queue as one job.
// ----------------------------------------------------------------------------
module mtef_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  mtef_pkg::t_in_item    i_data,
    input  logic                  i_q_ready,
    output logic                  o_job_valid,
    output mtef_pkg::t_job        o_job,
    output mtef_pkg::t_front_stat o_stat
);

    mtef_pkg::t_phase r_phase, n_phase;
    logic [27:0] r_carried, n_carried;
    logic [27:0] r_dbr, n_dbr;
    logic [7:0]  r_rs, n_rs;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_skip, n_skip;
    logic [1:0]  r_dbl, n_dbl;
    logic        r_keep, n_keep;
    logic [7:0]  r_first, n_first;
    logic        r_expl, n_expl;

    logic        accept;
    logic [7:0]  b;
    logic [27:0] delta_sum;
    logic        do_finish;
    logic        fin_expl;
    logic        meta_kept;
    mtef_pkg::t_job job;
    logic        job_valid;

    assign accept    = i_valid && i_q_ready;
    assign b         = i_data.in_byte;
    assign delta_sum = mtef_pkg::sat_add(r_carried, r_dbr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mtef_pkg::PH_DELTA;
            r_carried <= '0;
            r_dbr     <= '0;
            r_rs      <= mtef_pkg::ST_RESET;
            r_kind    <= '0;
            r_skip    <= '0;
            r_dbl     <= '0;
            r_keep    <= 1'b0;
            r_first   <= '0;
            r_expl    <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_carried <= n_carried;
            r_dbr     <= n_dbr;
            r_rs      <= n_rs;
            r_kind    <= n_kind;
            r_skip    <= n_skip;
            r_dbl     <= n_dbl;
            r_keep    <= n_keep;
            r_first   <= n_first;
            r_expl    <= n_expl;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_carried = r_carried;
        n_dbr     = r_dbr;
        n_rs      = r_rs;
        n_kind    = r_kind;
        n_skip    = r_skip;
        n_dbl     = r_dbl;
        n_keep    = r_keep;
        n_first   = r_first;
        n_expl    = r_expl;
        do_finish = 1'b0;
        fin_expl  = r_expl;
        meta_kept = 1'b0;
        job_valid = 1'b0;
        job       = '0;
        job.delta = delta_sum;

        unique case (r_phase)
            mtef_pkg::PH_STATUS: begin
                if (b == mtef_pkg::ST_SYSEX || b == mtef_pkg::ST_SYSEX_CT) begin
                    n_phase = mtef_pkg::PH_SYSLEN;
                end else if (b == mtef_pkg::ST_META) begin
                    n_phase = mtef_pkg::PH_MTYPE;
                end else if (!b[7]) begin
                    // running status: this byte is already data
                    n_expl  = 1'b0;
                    n_first = b;
                    if (mtef_pkg::data_len(r_rs) == 2'd1) begin
                        do_finish = 1'b1;
                        fin_expl  = 1'b0;
                    end else begin
                        n_dbl   = 2'd1;
                        n_phase = mtef_pkg::PH_DATA;
                    end
                end else begin
                    n_rs    = b;
                    n_expl  = 1'b1;
                    n_dbl   = mtef_pkg::data_len(b);
                    n_phase = mtef_pkg::PH_DATA;
                end
            end
            mtef_pkg::PH_DATA: begin
                if (r_dbl >= 2'd2) begin
                    n_first = b;
                    n_dbl   = 2'd1;
                end else begin
                    do_finish = 1'b1;
                end
            end
            mtef_pkg::PH_SYSLEN: begin
                n_carried = delta_sum;
                n_dbr     = '0;
                n_keep    = 1'b0;
                n_skip    = b;
                n_phase   = (b == 8'd0) ? mtef_pkg::PH_DELTA : mtef_pkg::PH_SKIP;
            end
            mtef_pkg::PH_MTYPE: begin
                n_kind  = b;
                n_phase = mtef_pkg::PH_MLEN;
            end
            mtef_pkg::PH_MLEN: begin
                meta_kept = (r_kind == mtef_pkg::META_EOT) ||
                            (r_kind == mtef_pkg::META_TEMPO && b >= mtef_pkg::TEMPO_MIN_LEN);
                if (meta_kept) begin
                    if (b == 8'd0 || !i_data.in_last) begin
                        job_valid     = 1'b1;
                        job.has_delta = 1'b1;
                        job.n_tail    = 2'd3;
                        job.tail      = {mtef_pkg::ST_META, r_kind, b};
                        n_carried     = '0;
                        n_dbr         = '0;
                    end
                end else begin
                    n_carried = delta_sum;
                    n_dbr     = '0;
                end
                n_keep  = meta_kept && (b != 8'd0);
                n_skip  = b;
                n_phase = (b == 8'd0) ? mtef_pkg::PH_DELTA : mtef_pkg::PH_SKIP;
            end
            mtef_pkg::PH_SKIP: begin
                if (r_keep) begin
                    job_valid  = 1'b1;
                    job.n_tail = 2'd1;
                    job.tail   = {16'h0000, b};
                end
                n_skip = (r_skip != 8'd0) ? r_skip - 8'd1 : r_skip;
                if (n_skip == 8'd0) begin
                    n_keep  = 1'b0;
                    n_phase = mtef_pkg::PH_DELTA;
                end
            end
            default: begin
                // accumulate the delta quantity, saturating on overflow
                if (r_dbr[27:21] != 7'd0) begin
                    n_dbr = mtef_pkg::DELTA_MAX;
                end else begin
                    n_dbr = {r_dbr[20:0], b[6:0]};
                end
                n_phase = b[7] ? mtef_pkg::PH_DELTA : mtef_pkg::PH_STATUS;
            end
        endcase

        if (do_finish) begin
            if (mtef_pkg::status_kept(r_rs)) begin
                job_valid     = 1'b1;
                job.has_delta = 1'b1;
                job.n_tail    = 2'd1;
                job.tail      = {16'h0000, b};
                // prepend data, then status, ahead of the final byte
                if (mtef_pkg::data_len(r_rs) == 2'd2) begin
                    job.tail   = {job.tail[1:0], 8'h00};
                    job.tail   = {job.tail[2], r_first, job.tail[0]};
                    job.tail   = {8'h00, r_first, b};
                    job.n_tail = 2'd2;
                end
                if (fin_expl) begin
                    job.tail   = (job.n_tail == 2'd2) ? {r_rs, r_first, b} : {8'h00, r_rs, b};
                    job.n_tail = job.n_tail + 2'd1;
                end
                n_carried = '0;
                n_dbr     = '0;
            end else begin
                n_carried = delta_sum;
                n_dbr     = '0;
            end
            n_dbl   = '0;
            n_phase = mtef_pkg::PH_DELTA;
        end

        // track end: back to the reset state, carried delta is dropped
        if (i_data.in_last) begin
            n_phase   = mtef_pkg::PH_DELTA;
            n_carried = '0;
            n_dbr     = '0;
            n_rs      = mtef_pkg::ST_RESET;
            n_kind    = '0;
            n_skip    = '0;
            n_dbl     = '0;
            n_keep    = 1'b0;
            n_first   = '0;
            n_expl    = 1'b0;
        end
    end

    assign o_job_valid         = accept && job_valid;
    assign o_job               = job;
    assign o_stat.phase        = r_phase;
    assign o_stat.carried_zero = (r_carried == 28'd0);

endmodule

// ===== design/mtef_queue.sv =====
// ----------------------------------------------------------------------------
// MIDI track event filter - job queue
// Small FIFO of output jobs that decouples the parser from the emitter.
// ----------------------------------------------------------------------------
module mtef_queue #(
    parameter int unsigned DEPTH = mtef_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mtef_pkg::t_job i_job,
    output logic           o_ready,
    output logic           o_valid,
    output mtef_pkg::t_job o_job,
    input  logic           i_ready
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    mtef_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== design/mtef_emitter.sv =====
// ----------------------------------------------------------------------------
// MIDI track event filter - byte emitter
// Serializes one job per burst: delta as a variable-length quantity, then
// the tail bytes, through a registered output stage.
// ----------------------------------------------------------------------------
module mtef_emitter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  mtef_pkg::t_job       i_job,
    output logic                 o_job_ready,
    output logic                 o_valid,
    output mtef_pkg::t_out_item  o_data,
    input  logic                 i_ready,
    output mtef_pkg::t_back_stat o_stat
);

    logic        r_busy;
    logic [27:0] r_delta;
    logic [mtef_pkg::TAIL_MAX-1:0][7:0] r_tail;
    logic [2:0]  r_dcnt;
    logic [2:0]  r_total;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    mtef_pkg::t_out_item r_out;

    logic        slot_free;
    logic        gen;
    logic        is_last;
    logic        load;
    logic [2:0]  k_full;
    logic [1:0]  k;
    logic [2:0]  t_full;
    logic [6:0]  grp;
    logic [7:0]  byte_out;
    logic [2:0]  n_dcnt;

    assign slot_free   = !r_out_valid || i_ready;
    assign gen         = r_busy && slot_free;
    assign is_last     = (r_idx == r_total - 3'd1);
    assign o_job_ready = !r_busy || (gen && is_last);
    assign load        = i_job_valid && o_job_ready;

    // delta byte count of the incoming job
    always_comb begin
        if (!i_job.has_delta) begin
            n_dcnt = 3'd0;
        end else if (i_job.delta[27:21] != 7'd0) begin
            n_dcnt = 3'd4;
        end else if (i_job.delta[20:14] != 7'd0) begin
            n_dcnt = 3'd3;
        end else if (i_job.delta[13:7] != 7'd0) begin
            n_dcnt = 3'd2;
        end else begin
            n_dcnt = 3'd1;
        end
    end

    always_comb begin
        k_full = r_dcnt - 3'd1 - r_idx;
        k      = k_full[1:0];
        t_full = r_total - 3'd1 - r_idx;
        case (k)
            2'd0:    grp = r_delta[6:0];
            2'd1:    grp = r_delta[13:7];
            2'd2:    grp = r_delta[20:14];
            default: grp = r_delta[27:21];
        endcase
        if (r_idx < r_dcnt) begin
            byte_out = {(k != 2'd0), grp};
        end else begin
            byte_out = r_tail[t_full[1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (gen) begin
                if (is_last) begin
                    r_busy <= 1'b0;
                end
                r_idx <= r_idx + 3'd1;
            end
            if (slot_free) begin
                r_out_valid <= gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_delta <= i_job.delta;
            r_tail  <= i_job.tail;
            r_dcnt  <= n_dcnt;
            r_total <= n_dcnt + {1'b0, i_job.n_tail};
        end
        if (gen) begin
            r_out.out_byte        <= byte_out;
            r_out.out_last_of_run <= is_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_stat.busy = r_busy;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Track event filter testbench
// Feeds track chunk bytes through valid/ready with bursts and stalls, predicts
// the filtered byte stream in a local parser model and compares every
// output transfer in order. A short table of hand-checked cases comes first,
// then random tracks built mostly from well-formed events.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          RANDOM_ITEMS = 420;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_LIMIT  = 20000;
    localparam int          TIMEOUT_NS   = 3_000_000;
    localparam logic [27:0] DELTA_CAP    = 28'h0FFF_FFFF;

    localparam logic [7:0] SX_START      = 8'hF0;
    localparam logic [7:0] SX_CONT       = 8'hF7;
    localparam logic [7:0] META_LEAD     = 8'hFF;
    localparam logic [7:0] KIND_EOT      = 8'h2F;
    localparam logic [7:0] KIND_TEMPO    = 8'h51;
    localparam logic [7:0] STATUS_IDLE   = 8'h80;
    localparam logic [7:0] TEMPO_LEN_MIN = 8'd3;
    localparam logic [3:0] NIB_PROG      = 4'hC;
    localparam logic [3:0] NIB_PRESS     = 4'hD;
    localparam logic [3:0] NIB_SYS       = 4'hF;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_BUSY} t_rx_mode;

    // One stimulus byte; when typed is set, res holds n expected bytes,
    // first byte most significant.
    typedef struct packed {
        logic [7:0]  b;
        logic        last;
        logic        typed;
        logic [2:0]  n;
        logic [55:0] res;
    } t_row;

    localparam t_row DIRECTED [26] = '{
        // running status right after reset: note-off
        '{8'h00, 1'b0, 1'b1, 3'd0, 56'h0},
        '{8'h45, 1'b0, 1'b1, 3'd0, 56'h0},
        '{8'h7F, 1'b0, 1'b1, 3'd3, 56'h00457F},
        // five-byte delta saturates
        '{8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h7F, 1'b0, 1'b0, 3'd0, 56'h0},
        // channel pressure is dropped, its delta carried
        '{8'hD3, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h10, 1'b0, 1'b1, 3'd0, 56'h0},
        // empty sysex, dropped
        '{8'h01, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hF0, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h00, 1'b0, 1'b1, 3'd0, 56'h0},
        // pitch bend picks up the saturated carry: seven bytes
        '{8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hE0, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h7F, 1'b0, 1'b1, 3'd7, 56'hFFFFFF7FE0007F},
        // tempo cut off by the track end after its header went out
        '{8'h00, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'hFF, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h51, 1'b0, 1'b0, 3'd0, 56'h0},
        '{8'h03, 1'b0, 1'b1, 3'd4, 56'h00FF5103},
        '{8'h07, 1'b0, 1'b1, 3'd1, 56'h07},
        '{8'hA1, 1'b1, 1'b1, 3'd1, 56'hA1},
        // note-on cut off by the track end
        '{8'h00, 1'b0, 1'b1, 3'd0, 56'h0},
        '{8'h90, 1'b0, 1'b1, 3'd0, 56'h0},
        '{8'h3C, 1'b1, 1'b1, 3'd0, 56'h0}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    mtef_pkg::t_in_item  in_data;
    logic                out_valid;
    logic                out_ready;
    mtef_pkg::t_out_item out_data;

    t_row                cur_row;
    t_row                stim_q[$];
    logic [7:0]          track_q[$];
    logic [7:0]          run_q[$];
    mtef_pkg::t_out_item pending_q[$];
    int                  errors;
    int                  results_seen;
    int                  burst_left;
    bit                  hold_req;

    // parser model state
    mtef_pkg::t_phase fl_phase;
    logic [27:0]      fl_carry;
    logic [27:0]      fl_delta;
    logic [7:0]       fl_status;
    logic [7:0]       fl_meta;
    logic [7:0]       fl_skip;
    logic [1:0]       fl_left;
    logic             fl_keep;
    logic [7:0]       fl_first;
    logic             fl_explicit;

    midi_track_event_filter_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #6 clk = ~clk;

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endfunction

    function automatic logic [1:0] msg_len(input logic [7:0] st);
        return (st[7:4] == NIB_PROG || st[7:4] == NIB_PRESS || st[7:4] == NIB_SYS) ?
               2'd1 : 2'd2;
    endfunction

    function automatic logic [27:0] delta_sum(input logic [27:0] a, input logic [27:0] b);
        logic [28:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, DELTA_CAP}) ? DELTA_CAP : s[27:0];
    endfunction

    function automatic void filter_reset();
        fl_phase    = mtef_pkg::PH_DELTA;
        fl_carry    = '0;
        fl_delta    = '0;
        fl_status   = STATUS_IDLE;
        fl_meta     = '0;
        fl_skip     = '0;
        fl_left     = '0;
        fl_keep     = 1'b0;
        fl_first    = '0;
        fl_explicit = 1'b0;
    endfunction

    function automatic void put_out(input logic [7:0] b);
        if (run_q.size() < 7) run_q.push_back(b);
    endfunction

    // Write carry plus current delta as a variable-length quantity.
    function automatic void put_delta();
        logic [27:0] v;
        int          cnt;
        v = delta_sum(fl_carry, fl_delta);
        cnt = 1;
        while (cnt < 4 && (v >> (7 * cnt)) != 0) cnt++;
        while (cnt > 0) begin
            cnt--;
            put_out({cnt != 0, v[7 * cnt +: 7]});
        end
        fl_carry = '0;
        fl_delta = '0;
    endfunction

    function automatic void fold_delta();
        fl_carry = delta_sum(fl_carry, fl_delta);
        fl_delta = '0;
    endfunction

    function automatic void finish_voice(input logic [7:0] b);
        if (fl_status[7:4] != NIB_PRESS && fl_status[7:4] != NIB_SYS) begin
            put_delta();
            if (fl_explicit) put_out(fl_status);
            if (msg_len(fl_status) == 2'd2) put_out(fl_first);
            put_out(b);
        end else begin
            fold_delta();
        end
        fl_left  = '0;
        fl_phase = mtef_pkg::PH_DELTA;
    endfunction

    // Advance the parser model by one track byte; output bytes go to run_q.
    function automatic void filter_step(input logic [7:0] b, input logic last);
        logic kept;
        case (fl_phase)
            mtef_pkg::PH_STATUS: begin
                if (b == SX_START || b == SX_CONT) begin
                    fl_phase = mtef_pkg::PH_SYSLEN;
                end else if (b == META_LEAD) begin
                    fl_phase = mtef_pkg::PH_MTYPE;
                end else if (!b[7]) begin
                    fl_explicit = 1'b0;
                    fl_first    = b;
                    if (msg_len(fl_status) == 2'd1) begin
                        finish_voice(b);
                    end else begin
                        fl_left  = 2'd1;
                        fl_phase = mtef_pkg::PH_DATA;
                    end
                end else begin
                    fl_status   = b;
                    fl_explicit = 1'b1;
                    fl_left     = msg_len(b);
                    fl_phase    = mtef_pkg::PH_DATA;
                end
            end
            mtef_pkg::PH_DATA: begin
                if (fl_left >= 2'd2) begin
                    fl_first = b;
                    fl_left  = 2'd1;
                end else begin
                    finish_voice(b);
                end
            end
            mtef_pkg::PH_SYSLEN: begin
                fold_delta();
                fl_keep  = 1'b0;
                fl_skip  = b;
                fl_phase = (b == 8'd0) ? mtef_pkg::PH_DELTA : mtef_pkg::PH_SKIP;
            end
            mtef_pkg::PH_MTYPE: begin
                fl_meta  = b;
                fl_phase = mtef_pkg::PH_MLEN;
            end
            mtef_pkg::PH_MLEN: begin
                kept = (fl_meta == KIND_EOT) || (fl_meta == KIND_TEMPO && b >= TEMPO_LEN_MIN);
                if (kept) begin
                    // a header with a nonzero length that would land on the track end is held back
                    if (b == 8'd0 || !last) begin
                        put_delta();
                        put_out(META_LEAD);
                        put_out(fl_meta);
                        put_out(b);
                    end
                end else begin
                    fold_delta();
                end
                fl_keep  = kept && (b != 8'd0);
                fl_skip  = b;
                fl_phase = (b == 8'd0) ? mtef_pkg::PH_DELTA : mtef_pkg::PH_SKIP;
            end
            mtef_pkg::PH_SKIP: begin
                if (fl_keep) put_out(b);
                if (fl_skip != 8'd0) fl_skip = fl_skip - 8'd1;
                if (fl_skip == 8'd0) begin
                    fl_keep  = 1'b0;
                    fl_phase = mtef_pkg::PH_DELTA;
                end
            end
            default: begin
                if (fl_delta > (DELTA_CAP >> 7)) fl_delta = DELTA_CAP;
                else fl_delta = {fl_delta[20:0], b[6:0]};
                fl_phase = b[7] ? mtef_pkg::PH_DELTA : mtef_pkg::PH_STATUS;
            end
        endcase
        if (last) filter_reset();
    endfunction

    function automatic void add_delta();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) begin
            repeat ($urandom_range(3, 5)) track_q.push_back(8'hFF);
        end else if (k < 5) begin
            repeat ($urandom_range(1, 2)) track_q.push_back(8'($urandom_range(128, 255)));
        end
        track_q.push_back(8'($urandom_range(0, 127)));
    endfunction

    // Build one track, mostly well-formed events, sometimes cut short.
    function automatic void build_track();
        int         kind;
        int         len;
        int         cut;
        int         k;
        int         rs_len;
        logic [7:0] st;
        t_row       r;
        rs_len = 2;
        repeat ($urandom_range(1, 10)) begin
            add_delta();
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
                track_q.push_back(st);
                rs_len = (st[7:4] == NIB_PROG || st[7:4] == NIB_PRESS) ? 1 : 2;
                repeat (rs_len) track_q.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 55) begin
                repeat (rs_len) track_q.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 62) begin
                do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == SX_CONT);
                track_q.push_back(st);
                track_q.push_back(8'($urandom_range(0, 127)));
                rs_len = 1;
            end else if (kind < 72) begin
                track_q.push_back($urandom_range(0, 1) ? SX_START : SX_CONT);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
                track_q.push_back(8'(len));
                repeat (len) track_q.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 92) begin
                track_q.push_back(META_LEAD);
                k = $urandom_range(0, 9);
                track_q.push_back(k < 5 ? KIND_TEMPO : k < 7 ? KIND_EOT :
                                  8'($urandom_range(0, 255)));
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
                track_q.push_back(8'(len));
                repeat (len) track_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 4)) track_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) < 6) begin
            add_delta();
            track_q.push_back(META_LEAD);
            track_q.push_back(KIND_EOT);
            track_q.push_back(8'd0);
        end
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, track_q.size()) : track_q.size();
        for (k = 0; k < cut; k++) begin
            r = '0;
            r.b    = track_q[k];
            r.last = (k == cut - 1);
            stim_q.push_back(r);
        end
        track_q.delete();
    endfunction

    // Offer one byte, hold it until the transfer, then maybe idle.
    task automatic send_row(input t_row r);
        int gap;
        @(negedge clk);
        cur_row  = r;
        in_data  <= '{in_byte: r.b, in_last: r.last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) :
                         $urandom_range(0, 15);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    // Predict on each input transfer, check each output transfer.
    always @(posedge clk) begin
        mtef_pkg::t_out_item want;
        int                  k;
        if (rst_n && in_valid && in_ready) begin
            run_q.delete();
            filter_step(cur_row.b, cur_row.last);
            if (cur_row.typed) begin
                run_q.delete();
                for (k = 0; k < int'(cur_row.n); k++)
                    run_q.push_back(cur_row.res[(int'(cur_row.n) - 1 - k) * 8 +: 8]);
            end
            for (k = 0; k < run_q.size(); k++) begin
                want.out_byte        = run_q[k];
                want.out_last_of_run = (k == run_q.size() - 1);
                pending_q.push_back(want);
            end
        end
        if (rst_n && out_valid && out_ready) begin
            if (pending_q.size() == 0) begin
                note_error($sformatf("output %0d: none expected, got byte %02h last %b",
                                     results_seen, out_data.out_byte,
                                     out_data.out_last_of_run));
            end else begin
                want = pending_q.pop_front();
                if (want.out_byte !== out_data.out_byte ||
                    want.out_last_of_run !== out_data.out_last_of_run)
                    note_error($sformatf(
                        "output %0d: expected byte %02h last %b, got byte %02h last %b",
                        results_seen, want.out_byte, want.out_last_of_run,
                        out_data.out_byte, out_data.out_last_of_run));
            end
            results_seen++;
        end
    end

    // Receiver: random stall pattern, plus one long hold-off on request.
    initial begin
        t_rx_mode mode;
        int       span;
        out_ready = 1'b0;
        mode      = RX_FREE;
        span      = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                span     = 0;
            end else begin
                if (span == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    span = $urandom_range(16, 80);
                end
                span--;
                case (mode)
                    RX_FREE:   out_ready <= 1'b1;
                    RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cur_row      = '0;
        errors       = 0;
        results_seen = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        filter_reset();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_row(DIRECTED[i]);
        wait_drained();
        repeat (20) @(posedge clk);

        while (stim_q.size() < RANDOM_ITEMS) build_track();
        for (i = 0; i < stim_q.size(); i++) begin
            // keep offering bytes while the receiver holds off
            if (i == 120) hold_req = 1'b1;
            if (i == 300) wait_drained();
            send_row(stim_q[i]);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        for (i = 0; i < DRAIN_LIMIT && pending_q.size() != 0; i++) @(posedge clk);
        repeat (40) @(posedge clk);
        if (pending_q.size() != 0)
            note_error($sformatf("%0d expected output bytes never arrived", pending_q.size()));
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/mtef_pkg.sv
design/mtef_front.sv
design/mtef_queue.sv
design/mtef_emitter.sv
design/midi_track_event_filter_unit.sv
tb/tb_top.sv
